@@ rtl/lif_pkg.sv @@
`default_nettype none
package lif_pkg;

	// Field widths
	localparam int IDX_W   = 8;
	localparam int IN_W    = 15;
	localparam int MOD_W   = 12;
	localparam int REG_W   = 13;
	localparam int VM_W    = 16;
	localparam int GAIN_W  = 24;
	localparam int FRAC_W  = 12;

	// Configuration port
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_PERSIST = 2'd0;
	localparam logic [1:0] REG_THRESH  = 2'd1;
	localparam logic [1:0] REG_RSTAMT  = 2'd2;

	// Q1.12 one, divider numerator is 2^(2*FRAC_W)
	localparam logic [REG_W-1:0] ONE_Q12 = 13'd4096;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFF_FFFF;

	// Membrane saturation bounds
	localparam logic signed [19:0] VM_MAX = 20'sd32767;
	localparam logic signed [19:0] VM_MIN = -20'sd32768;

	typedef struct packed {
		logic [REG_W-1:0] persist;
		logic [REG_W-1:0] thresh;
		logic [REG_W-1:0] rst_amt;
	} cfg_t;

	typedef struct packed {
		logic              spike;
		logic              back;
		logic [IDX_W-1:0]  idx;
	} core_res_t;

endpackage
`default_nettype wire

@@ rtl/lif_regs.sv @@
`default_nettype none
module lif_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lif_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lif_pkg::DATA_W-1:0]  pwdata,
	output logic      [lif_pkg::DATA_W-1:0]  prdata,
	output lif_pkg::cfg_t                    cfg
);

	lif_pkg::cfg_t cfg_q;
	logic [1:0]    reg_sel;
	logic          wr_en;

	assign reg_sel = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Register writes; out-of-list addresses are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				lif_pkg::REG_PERSIST: cfg_q.persist <= pwdata[lif_pkg::REG_W-1:0];
				lif_pkg::REG_THRESH:  cfg_q.thresh  <= pwdata[lif_pkg::REG_W-1:0];
				lif_pkg::REG_RSTAMT:  cfg_q.rst_amt <= pwdata[lif_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			lif_pkg::REG_PERSIST: prdata[lif_pkg::REG_W-1:0] = cfg_q.persist;
			lif_pkg::REG_THRESH:  prdata[lif_pkg::REG_W-1:0] = cfg_q.thresh;
			lif_pkg::REG_RSTAMT:  prdata[lif_pkg::REG_W-1:0] = cfg_q.rst_amt;
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/lif_div.sv @@
`default_nettype none
// Shunt gain 2^24 / (4096 - modulation), restoring division, one quotient bit a cycle
module lif_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lif_pkg::MOD_W-1:0]   modulation,
	output logic                             running,
	output logic                             done,
	output logic      [lif_pkg::GAIN_W-1:0]  gain
);

	localparam int QW = lif_pkg::GAIN_W + 1;
	localparam int CW = $clog2(QW);

	logic [lif_pkg::REG_W-1:0] den_q;
	logic [lif_pkg::REG_W-1:0] rem_q;
	logic [QW-1:0]             quo_q;
	logic [CW-1:0]             cnt_q;
	logic                      run_q;
	logic                      done_q;

	logic                      num_bit;
	logic [lif_pkg::REG_W:0]   rem_sh;
	logic                      q_bit;
	logic [lif_pkg::REG_W:0]   rem_nx;

	// Numerator has only its top bit set
	assign num_bit = (cnt_q == CW'(QW - 1));
	assign rem_sh  = {rem_q, num_bit};
	assign q_bit   = (rem_sh >= {1'b0, den_q});
	assign rem_nx  = q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(QW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= lif_pkg::ONE_Q12 - {1'b0, modulation};
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_nx[lif_pkg::REG_W-1:0];
			quo_q <= {quo_q[QW-2:0], q_bit};
		end
	end

	assign running = run_q;
	assign done    = done_q;
	assign gain    = quo_q[QW-1] ? lif_pkg::GAIN_MAX : quo_q[lif_pkg::GAIN_W-1:0];

endmodule
`default_nettype wire

@@ rtl/lif_core.sv @@
`default_nettype none
// Membrane/last-spike store with a three-step read-modify-write
module lif_core #(
	parameter int NEURONS = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [lif_pkg::IDX_W-1:0]   neuron_index,
	input  wire logic [lif_pkg::IN_W-1:0]    excitation,
	input  wire logic [lif_pkg::IN_W-1:0]    inhibition,
	input  wire lif_pkg::cfg_t               cfg,
	output lif_pkg::core_res_t               res
);

	localparam int SPAN  = 1 << lif_pkg::IDX_W;
	localparam int DEPTH = (NEURONS < SPAN) ? NEURONS : SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = lif_pkg::VM_W + 1;

	// Entry: {last spike, membrane}
	logic [EW-1:0]     mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;

	logic [AW-1:0]              addr_q;
	logic [lif_pkg::IDX_W-1:0]  idx_q;
	logic                       in_rng_q;
	logic [lif_pkg::IN_W-1:0]   exc_q;
	logic [lif_pkg::IN_W-1:0]   inh_q;
	logic                       in_rng;
	logic [AW-1:0]              addr;

	logic [EW-1:0]              rd_q;
	logic                       vld_s1;
	logic                       st1_q, st2_q, st3_q;

	logic signed [29:0]         prod_s2;
	logic                       back_s2;
	logic signed [15:0]         vm_s3;
	logic                       spk_s3;
	logic                       back_s3;

	logic                       spike_q;
	logic                       back_q;

	logic signed [15:0]         vm_rd;
	logic signed [17:0]         leak;
	logic signed [19:0]         sum;
	logic signed [15:0]         vm_sat;
	logic                       spk;
	logic signed [17:0]         dif;
	logic signed [15:0]         vm_new;

	assign in_rng = ({24'd0, neuron_index} < 32'(NEURONS));
	assign addr   = neuron_index[AW-1:0];

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st1_q <= 1'b0;
			st2_q <= 1'b0;
			st3_q <= 1'b0;
		end else begin
			st1_q <= start;
			st2_q <= st1_q;
			st3_q <= st2_q;
		end
	end

	// Item capture and memory read
	always_ff @(posedge clk) begin
		if (start) begin
			idx_q    <= neuron_index;
			addr_q   <= addr;
			in_rng_q <= in_rng;
			exc_q    <= excitation;
			inh_q    <= inhibition;
			rd_q     <= mem[addr];
			vld_s1   <= in_rng & valid_q[addr];
		end
	end

	// Stage 1: leak product
	assign vm_rd = vld_s1 ? $signed(rd_q[lif_pkg::VM_W-1:0]) : 16'sd0;

	always_ff @(posedge clk) begin
		if (st1_q) begin
			prod_s2 <= 30'(vm_rd) * 30'($signed({1'b0, cfg.persist}));
			back_s2 <= vld_s1 & rd_q[lif_pkg::VM_W];
		end
	end

	// Stage 2: floor shift, integrate, saturate, threshold
	always_comb begin
		leak = prod_s2[29:lif_pkg::FRAC_W];
		sum  = 20'(leak) + $signed({5'd0, exc_q}) - $signed({5'd0, inh_q});
		if (sum > lif_pkg::VM_MAX) begin
			vm_sat = 16'sh7FFF;
		end else if (sum < lif_pkg::VM_MIN) begin
			vm_sat = -16'sh8000;
		end else begin
			vm_sat = sum[15:0];
		end
		spk = ($signed({vm_sat[15], vm_sat}) >= $signed({4'd0, cfg.thresh}));
	end

	always_ff @(posedge clk) begin
		if (st2_q) begin
			vm_s3   <= vm_sat;
			spk_s3  <= spk;
			back_s3 <= back_s2;
		end
	end

	// Stage 3: reset subtraction and write-back
	always_comb begin
		dif = $signed({{2{vm_s3[15]}}, vm_s3}) - $signed({5'd0, cfg.rst_amt});
		if (!spk_s3) begin
			vm_new = vm_s3;
		end else if (dif < -18'sd32768) begin
			vm_new = -16'sh8000;
		end else begin
			vm_new = dif[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (st3_q && in_rng_q) begin
			mem[addr_q] <= {spk_s3, vm_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			spike_q <= 1'b0;
			back_q  <= 1'b0;
		end else if (st3_q) begin
			if (in_rng_q) begin
				valid_q[addr_q] <= 1'b1;
			end
			spike_q <= in_rng_q & spk_s3;
			back_q  <= in_rng_q & back_s3;
		end
	end

	assign res.spike = spike_q;
	assign res.back  = back_q;
	assign res.idx   = idx_q;

endmodule
`default_nettype wire

@@ rtl/leaky_integrate_fire_neuron.sv @@
// Channel   Ports                                                    Moves
// config    psel penable pwrite paddr pwdata prdata pready           register beat, APB
// item in   start busy neuron_index excitation inhibition modulation accepted: start & !busy
// result    done neuron_out_index spike backprop_spike shunt_gain    one cycle, on done
//
// The shunt divider yields one quotient bit per cycle (25 bits) and the result
// strobes in the cycle after the last bit; no new item is taken while busy.
// busy is high from the accepting edge until the result cycle; a new item may be
// taken in the same cycle that done is high. The membrane store update (read,
// multiply, integrate, write back) finishes well inside the divide time.
// Reset clears config and control registers and per-neuron valid bits at once; no sweep.
// The receiver cannot stall; each result is flagged by done for exactly one cycle.
`default_nettype none
module leaky_integrate_fire_neuron #(
	parameter int NEURONS = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lif_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lif_pkg::DATA_W-1:0]  pwdata,
	output logic      [lif_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [lif_pkg::IDX_W-1:0]   neuron_index,
	input  wire logic [lif_pkg::IN_W-1:0]    excitation,
	input  wire logic [lif_pkg::IN_W-1:0]    inhibition,
	input  wire logic [lif_pkg::MOD_W-1:0]   modulation,
	output logic                             done,
	output logic      [lif_pkg::IDX_W-1:0]   neuron_out_index,
	output logic                             spike,
	output logic                             backprop_spike,
	output logic      [lif_pkg::GAIN_W-1:0]  shunt_gain
);

	lif_pkg::cfg_t      cfg;
	lif_pkg::core_res_t res;
	logic               accept;
	logic               div_run;

	assign accept = start & ~div_run;
	assign busy   = div_run;
	assign pready = 1'b1;

	lif_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lif_core #(
		.NEURONS (NEURONS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.neuron_index (neuron_index),
		.excitation   (excitation),
		.inhibition   (inhibition),
		.cfg          (cfg),
		.res          (res)
	);

	lif_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.modulation (modulation),
		.running    (div_run),
		.done       (done),
		.gain       (shunt_gain)
	);

	// Result fields hold until the next accepted item
	assign neuron_out_index = res.idx;
	assign spike            = res.spike;
	assign backprop_spike   = res.back;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb;

	localparam int NEURONS = 256;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic [1:0] {ACT_STEP, ACT_WRITE, ACT_DRAIN, ACT_PACE} act_kind_t;

	// One entry of the stimulus queue: a neuron step, a register write,
	// a pause until drained, or a change of the sender's idle rate
	typedef struct {
		act_kind_t                  kind;
		logic [lif_pkg::IDX_W-1:0]  idx;
		logic [lif_pkg::IN_W-1:0]   exc;
		logic [lif_pkg::IN_W-1:0]   inh;
		logic [lif_pkg::MOD_W-1:0]  modv;
		logic [1:0]                 reg_sel;
		logic [lif_pkg::DATA_W-1:0] data;
		int                         pct;
	} action_t;

	typedef struct {
		logic [lif_pkg::IDX_W-1:0]  idx;
		logic                       spike;
		logic                       back;
		logic [lif_pkg::GAIN_W-1:0] gain;
	} neuron_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [lif_pkg::ADDR_W-1:0] paddr = '0;
	logic [lif_pkg::DATA_W-1:0] pwdata = '0;
	logic [lif_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [lif_pkg::IDX_W-1:0] neuron_index = '0;
	logic [lif_pkg::IN_W-1:0] excitation = '0;
	logic [lif_pkg::IN_W-1:0] inhibition = '0;
	logic [lif_pkg::MOD_W-1:0] modulation = '0;
	logic done;
	logic [lif_pkg::IDX_W-1:0] neuron_out_index;
	logic spike;
	logic backprop_spike;
	logic [lif_pkg::GAIN_W-1:0] shunt_gain;

	leaky_integrate_fire_neuron #(.NEURONS(NEURONS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.neuron_index(neuron_index), .excitation(excitation),
		.inhibition(inhibition), .modulation(modulation),
		.done(done), .neuron_out_index(neuron_out_index), .spike(spike),
		.backprop_spike(backprop_spike), .shunt_gain(shunt_gain)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the neuron population and its settings
	logic signed [lif_pkg::VM_W-1:0] vm_state [NEURONS] = '{default: '0};
	logic fired_state [NEURONS] = '{default: 1'b0};
	logic [lif_pkg::REG_W-1:0] persist_q = '0;
	logic [lif_pkg::REG_W-1:0] thresh_q = '0;
	logic [lif_pkg::REG_W-1:0] rstamt_q = '0;

	action_t pending[$];
	neuron_result_t pending_results[$];

	int mismatches = 0;
	int items_sent = 0;
	int writes_done = 0;
	int results_checked = 0;
	int spikes_seen = 0;
	int stall_cycles = 0;
	int idle_pct = 0;
	logic drv_start;
	action_t hd;
	neuron_result_t hd_res;

	function automatic longint clamp_vm(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// One neuron time step on the shadow state; queues the result it must give
	task automatic step_neuron(input logic [lif_pkg::IDX_W-1:0] idx,
			input logic [lif_pkg::IN_W-1:0] exc, input logic [lif_pkg::IN_W-1:0] inh,
			input logic [lif_pkg::MOD_W-1:0] modv);
		neuron_result_t r;
		longint vm;
		longint quot;
		r.idx = idx;
		r.spike = 1'b0;
		r.back = 1'b0;
		if (idx < NEURONS) begin
			// leak with floor, then integrate and saturate
			vm = (longint'(vm_state[idx]) * longint'(persist_q)) >>> lif_pkg::FRAC_W;
			vm = clamp_vm(vm + longint'(exc) - longint'(inh));
			if (vm >= longint'(thresh_q)) begin
				r.spike = 1'b1;
				vm = clamp_vm(vm - longint'(rstamt_q));
			end
			r.back = fired_state[idx];
			vm_state[idx] = vm[lif_pkg::VM_W-1:0];
			fired_state[idx] = r.spike;
		end
		// shunt gain 2^24 / (4096 - modulation), saturated
		quot = (longint'(1) << 24) / (longint'(lif_pkg::ONE_Q12) - longint'(modv));
		if (quot > longint'(lif_pkg::GAIN_MAX))
			quot = longint'(lif_pkg::GAIN_MAX);
		r.gain = quot[lif_pkg::GAIN_W-1:0];
		pending_results.push_back(r);
	endtask

	task automatic write_register(input logic [lif_pkg::ADDR_W-1:0] addr,
			input logic [lif_pkg::DATA_W-1:0] data);
		case (addr[3:2])
			lif_pkg::REG_PERSIST: persist_q = data[lif_pkg::REG_W-1:0];
			lif_pkg::REG_THRESH:  thresh_q = data[lif_pkg::REG_W-1:0];
			lif_pkg::REG_RSTAMT:  rstamt_q = data[lif_pkg::REG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Stimulus queue builders
	task automatic queue_step(input logic [lif_pkg::IDX_W-1:0] idx,
			input logic [lif_pkg::IN_W-1:0] exc, input logic [lif_pkg::IN_W-1:0] inh,
			input logic [lif_pkg::MOD_W-1:0] modv);
		action_t a;
		a = '{kind: ACT_STEP, idx: idx, exc: exc, inh: inh, modv: modv,
			reg_sel: '0, data: '0, pct: 0};
		pending.push_back(a);
	endtask

	task automatic queue_write(input logic [1:0] sel, input logic [lif_pkg::REG_W-1:0] value);
		action_t a;
		logic [lif_pkg::DATA_W-1:0] junk;
		// upper bits carry noise; only the low register bits count
		junk = $urandom;
		a = '{kind: ACT_WRITE, idx: '0, exc: '0, inh: '0, modv: '0, reg_sel: sel,
			data: {junk[lif_pkg::DATA_W-1:lif_pkg::REG_W], value}, pct: 0};
		pending.push_back(a);
	endtask

	task automatic queue_ctl(input act_kind_t kind, input int pct);
		action_t a;
		a = '{kind: kind, idx: '0, exc: '0, inh: '0, modv: '0, reg_sel: '0,
			data: '0, pct: pct};
		pending.push_back(a);
	endtask

	function automatic logic [lif_pkg::IDX_W-1:0] pick_neuron();
		// mostly a few neurons so their state runs deep
		if ($urandom_range(99) < 70)
			return lif_pkg::IDX_W'($urandom_range(7));
		return lif_pkg::IDX_W'($urandom_range(255));
	endfunction

	function automatic logic [lif_pkg::IN_W-1:0] pick_drive();
		case ($urandom_range(6))
			0: return '0;
			1: return lif_pkg::IN_W'(32767);
			2: return lif_pkg::IN_W'($urandom_range(32767));
			3: return lif_pkg::IN_W'($urandom_range(12000));
			default: return lif_pkg::IN_W'($urandom_range(4096));
		endcase
	endfunction

	function automatic logic [lif_pkg::MOD_W-1:0] pick_mod();
		case ($urandom_range(5))
			0: return '0;
			1: return lif_pkg::MOD_W'(4095);
			2: return lif_pkg::MOD_W'($urandom_range(4095, 4000));
			default: return lif_pkg::MOD_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [lif_pkg::REG_W-1:0] pick_level();
		case ($urandom_range(5))
			0: return '0;
			1: return lif_pkg::REG_W'(4096);
			2: return lif_pkg::REG_W'(8191);
			3: return lif_pkg::REG_W'($urandom_range(8191));
			default: return lif_pkg::REG_W'($urandom_range(4096));
		endcase
	endfunction

	// Driver: item beats and register writes from the stimulus queue
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			psel <= 1'b0;
			penable <= 1'b0;
		end else begin
			drv_start = 1'b0;
			// item beat taken at this edge
			if (start && !busy) begin
				step_neuron(neuron_index, excitation, inhibition, modulation);
				void'(pending.pop_front());
				items_sent++;
			end
			if (psel && penable && pwrite && pready) begin
				// register write lands at this edge
				write_register(paddr, pwdata);
				void'(pending.pop_front());
				writes_done++;
				psel <= 1'b0;
				penable <= 1'b0;
			end else if (psel) begin
				penable <= 1'b1;
			end else if (pending.size() != 0) begin
				hd = pending[0];
				case (hd.kind)
					ACT_STEP: begin
						// sender may idle this cycle, at the current idle rate
						if ($urandom_range(99) >= idle_pct) begin
							drv_start = 1'b1;
							neuron_index <= hd.idx;
							excitation <= hd.exc;
							inhibition <= hd.inh;
							modulation <= hd.modv;
						end
					end
					ACT_WRITE: begin
						// only while the block is idle
						if (pending_results.size() == 0 && !busy && !done) begin
							psel <= 1'b1;
							pwrite <= 1'b1;
							paddr <= {hd.reg_sel, 2'b00};
							pwdata <= hd.data;
						end
					end
					ACT_DRAIN: begin
						if (pending_results.size() == 0 && !done)
							void'(pending.pop_front());
					end
					default: begin
						idle_pct = hd.pct;
						void'(pending.pop_front());
					end
				endcase
			end
			start <= drv_start;
		end
	end

	// Monitor: check each result beat, and the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("unexpected result, neuron", neuron_out_index, -1);
				end else begin
					hd_res = pending_results.pop_front();
					if (neuron_out_index !== hd_res.idx)
						flag_mismatch("neuron_out_index", neuron_out_index, hd_res.idx);
					if (spike !== hd_res.spike)
						flag_mismatch("spike", spike, hd_res.spike);
					if (backprop_spike !== hd_res.back)
						flag_mismatch("backprop_spike", backprop_spike, hd_res.back);
					if (shunt_gain !== hd_res.gain)
						flag_mismatch("shunt_gain", shunt_gain, hd_res.gain);
					results_checked++;
					if (hd_res.spike)
						spikes_seen++;
				end
			end
			if ((start && !busy) || done || (psel && penable)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", stall_cycles);
				$display("FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int pace_of [3];
		pace_of = '{17, 56, 0};

		// sender idles lightly first
		queue_ctl(ACT_PACE, pace_of[0]);

		// reset settings: zero threshold, so a zero membrane fires
		queue_step(8'd0, '0, '0, '0);
		queue_write(lif_pkg::REG_PERSIST, 13'd4096);
		queue_write(lif_pkg::REG_THRESH, 13'd4096);
		queue_write(lif_pkg::REG_RSTAMT, 13'd4096);
		queue_write(REG_SPARE, 13'h1FFF);

		// exactly at threshold, just below, then back at it
		queue_step(8'd1, 15'd4096, '0, 12'd2048);
		queue_step(8'd1, 15'd4095, '0, 12'd4095);
		queue_step(8'd1, 15'd1, '0, 12'd1);
		// saturation at the top and bottom of the membrane range
		queue_step(8'd2, 15'h7FFF, '0, '0);
		queue_step(8'd2, 15'h7FFF, '0, '0);
		queue_step(8'd3, '0, 15'h7FFF, 12'hFFF);
		queue_step(8'd3, '0, 15'h7FFF, 12'hFFF);
		queue_step(8'd255, 15'h7FFF, 15'h7FFF, 12'd1234);
		queue_step(8'd128, 15'd16384, 15'd8192, 12'd2048);

		// persistence above one amplifies, bounded by saturation
		queue_write(lif_pkg::REG_PERSIST, 13'h1FFF);
		queue_write(lif_pkg::REG_THRESH, 13'h1FFF);
		queue_write(lif_pkg::REG_RSTAMT, '0);
		queue_step(8'd2, '0, '0, '0);
		queue_step(8'd3, '0, '0, 12'd4094);
		queue_step(8'd4, 15'd4096, '0, 12'd100);
		queue_step(8'd4, '0, '0, 12'd3000);

		// full reset amount, then the floor of a negative leak
		queue_write(lif_pkg::REG_PERSIST, '0);
		queue_write(lif_pkg::REG_THRESH, '0);
		queue_write(lif_pkg::REG_RSTAMT, 13'h1FFF);
		queue_step(8'd5, '0, '0, '0);
		queue_step(8'd5, '0, 15'd1, '0);
		queue_write(lif_pkg::REG_PERSIST, 13'd2048);
		queue_step(8'd5, '0, '0, 12'd5);
		queue_step(8'd5, '0, '0, 12'd4095);
		queue_ctl(ACT_DRAIN, 0);

		// random part in three idle regimes, settings changed between groups
		for (int p = 0; p < 3; p++) begin
			queue_ctl(ACT_PACE, pace_of[p]);
			for (int g = 0; g < 10; g++) begin
				queue_write(lif_pkg::REG_PERSIST, pick_level());
				queue_write(lif_pkg::REG_THRESH, pick_level());
				queue_write(lif_pkg::REG_RSTAMT, pick_level());
				if (g % 4 == 0)
					queue_write(REG_SPARE, pick_level());
				for (int k = 0; k < 48; k++)
					queue_step(pick_neuron(), pick_drive(), pick_drive(), pick_mod());
				if (g == 5)
					queue_ctl(ACT_DRAIN, 0);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0)
			flag_mismatch("results never seen", pending_results.size(), 0);
		$display("ran %0d neuron steps and %0d register writes over three idle regimes",
			items_sent, writes_done);
		$display("checked %0d results, %0d of them spikes; %0d mismatches",
			results_checked, spikes_seen, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
